>>> sv/mbr_pkg.sv
// Shared field widths, op codes and controller/datapath handshake types for the bit reader.
`default_nettype none
package mbr_pkg;

   localparam int OP_W      = 3;
   localparam int ADDR_W    = 12;
   localparam int DATA_W    = 8;
   localparam int COUNT_W   = 16;
   localparam int VALUE_W   = 64;
   localparam int OFFSET_W  = 13;

   localparam int BYTE_BITS  = 8;
   localparam int WORD_BYTES = 8;
   localparam int WORD_BITS  = 64;
   localparam int NBITS_W    = 7;   // holds a bit count of 0 to 64

   localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
   localparam logic [OP_W-1:0] OP_READ    = 3'd1;
   localparam logic [OP_W-1:0] OP_SKIP    = 3'd2;
   localparam logic [OP_W-1:0] OP_TAKE    = 3'd3;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

   typedef struct packed {
      logic accept;      // request beat taken this cycle
      logic fetch_next;  // address the following memory word
      logic cap_hi;      // hold the first memory word
      logic cap_win;     // hold the left-aligned 64-bit window
      logic commit;      // load the response register and advance the position
   } mbr_cmd_type;

   typedef struct packed {
      logic is_read;     // the offered request is a bit read
   } mbr_stat_type;

endpackage
`default_nettype wire

>>> sv/mbr_if.sv
// Request and response channel interfaces of the bit reader.
`default_nettype none
interface mbr_req_if;
   import mbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [ADDR_W-1:0]   load_address;
   logic [DATA_W-1:0]   load_byte;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, op, load_address, load_byte, count, input ready);
   modport sink   (input valid, op, load_address, load_byte, count, output ready);
endinterface

interface mbr_rsp_if;
   import mbr_pkg::*;
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [OFFSET_W-1:0] byte_offset;
   logic                past_end;

   modport source (output valid, value, byte_offset, past_end, input ready);
   modport sink   (input valid, value, byte_offset, past_end, output ready);
endinterface
`default_nettype wire

>>> sv/mbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> sv/mbr_ctrl.sv
// Controller state machine: request acceptance, read sequencing and response register valid.
`default_nettype none
module mbr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire mbr_pkg::mbr_stat_type stat,
   output mbr_pkg::mbr_cmd_type      cmd
);
   import mbr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.is_read ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            cmd.cap_hi     = 1'b1;
            cmd.fetch_next = 1'b1;
            state_in       = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.cap_win = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            // wait for the response register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

>>> sv/mbr_dpath.sv
// Datapath: banked byte buffer, bit position, window alignment and response register.
`default_nettype none
module mbr_dpath #(
   parameter int BUFFER_BYTES  = 4096,
   parameter int MAX_READ_BITS = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire mbr_pkg::mbr_cmd_type             cmd,
   output mbr_pkg::mbr_stat_type                 stat,
   input  wire logic [mbr_pkg::OP_W-1:0]         req_op,
   input  wire logic [mbr_pkg::ADDR_W-1:0]       req_load_address,
   input  wire logic [mbr_pkg::DATA_W-1:0]       req_load_byte,
   input  wire logic [mbr_pkg::COUNT_W-1:0]      req_count,
   output logic      [mbr_pkg::VALUE_W-1:0]      rsp_value,
   output logic      [mbr_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic                                  rsp_past_end
);
   import mbr_pkg::*;

   localparam int END_BITS = BUFFER_BYTES * BYTE_BITS;
   localparam int PW       = $clog2(END_BITS + 1);
   localparam int WORDS    = (BUFFER_BYTES + WORD_BYTES - 1) / WORD_BYTES;
   localparam int AW       = $clog2(WORDS);
   localparam int AMT_W    = COUNT_W + $clog2(BYTE_BITS);
   localparam int CW       = (PW > AMT_W) ? PW : AMT_W;
   localparam int SH_W     = $clog2(WORD_BITS);
   localparam int BSEL_W   = $clog2(WORD_BYTES);

   // position and per-item state
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        tgt_ff, tgt_in;
   logic                 is_read_ff, is_read_in;
   logic [NBITS_W-1:0]   n_ff, n_in;
   logic [NBITS_W-1:0]   cut_ff, cut_in;
   logic                 over_ff, over_in;
   logic [OFFSET_W-1:0]  ofs_ff, ofs_in;
   logic [WORD_BITS-1:0] hi_ff, hi_in;
   logic [WORD_BITS-1:0] win_ff, win_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [OFFSET_W-1:0]  rofs_ff, rofs_in;
   logic                 rover_ff, rover_in;

   logic [CW-1:0]          pos_w, room, amt, adv_pos;
   logic                   cnt_over, run_over, is_read;
   logic [NBITS_W-1:0]     n_cnt;
   logic [AW-1:0]          word_idx, rd_word, wr_word;
   logic                   load_we;
   logic [BSEL_W-1:0]      wr_bank;
   logic [WORD_BITS-1:0]   ram_q;
   logic [2*WORD_BITS-1:0] shifted;
   logic [VALUE_W-1:0]     aligned, keep;

   // request decode and position arithmetic against the current position
   always_comb begin
      is_read  = (req_op == OP_READ);
      pos_w    = CW'(pos_ff);
      room     = CW'(END_BITS) - pos_w;
      cnt_over = req_count > COUNT_W'(MAX_READ_BITS);
      n_cnt    = cnt_over ? NBITS_W'(MAX_READ_BITS) : NBITS_W'(req_count);
      case (req_op)
         OP_READ: amt = CW'(n_cnt);
         OP_SKIP: amt = CW'(req_count);
         OP_TAKE: amt = CW'(req_count) << $clog2(BYTE_BITS);
         default: amt = '0;
      endcase
      run_over = amt > room;
      adv_pos  = run_over ? CW'(END_BITS) : pos_w + amt;
   end

   assign stat.is_read = is_read;

   // per-item registers, taken on the request beat
   always_comb begin
      is_read_in = is_read_ff;
      n_in       = n_ff;
      cut_in     = cut_ff;
      over_in    = over_ff;
      ofs_in     = ofs_ff;
      tgt_in     = tgt_ff;
      if (cmd.accept) begin
         is_read_in = is_read;
         n_in       = n_cnt;
         cut_in     = (is_read && run_over) ? NBITS_W'(amt - room) : '0;
         over_in    = run_over || (is_read && cnt_over);
         ofs_in     = (req_op == OP_TAKE) ? OFFSET_W'(pos_ff >> $clog2(BYTE_BITS)) : '0;
         case (req_op)
            OP_READ, OP_SKIP, OP_TAKE: tgt_in = PW'(adv_pos);
            OP_RESTART:                tgt_in = '0;
            default:                   tgt_in = pos_ff;
         endcase
      end
   end

   // buffer: eight byte banks, byte k of a word in bank k
   always_comb begin
      load_we  = cmd.accept && (req_op == OP_LOAD) &&
                 (32'(req_load_address) < 32'(BUFFER_BYTES));
      wr_word  = AW'(32'(req_load_address) >> BSEL_W);
      wr_bank  = req_load_address[BSEL_W-1:0];
      word_idx = AW'(pos_ff >> SH_W);
      rd_word  = cmd.fetch_next ? AW'(word_idx + 1'b1) : word_idx;
   end

   for (genvar k = 0; k < WORD_BYTES; k++) begin : g_bank
      mbr_ram #(
         .WIDTH (BYTE_BITS),
         .DEPTH (WORDS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (load_we && (wr_bank == BSEL_W'(k))),
         .wr_addr (wr_word),
         .wr_data (req_load_byte),
         .rd_addr (rd_word),
         .rd_data (ram_q[WORD_BITS-1-k*BYTE_BITS -: BYTE_BITS])
      );
   end

   // left-align the window at the position, then right-align the read bits
   always_comb begin
      hi_in   = cmd.cap_hi ? ram_q : hi_ff;
      shifted = {hi_ff, ram_q} << pos_ff[SH_W-1:0];
      win_in  = cmd.cap_win ? shifted[2*WORD_BITS-1:WORD_BITS] : win_ff;
      aligned = win_ff >> (NBITS_W'(WORD_BITS) - n_ff);
      // drop bits that fall past the buffer end
      keep    = {VALUE_W{1'b1}} << cut_ff;
   end

   always_comb begin
      value_in = value_ff;
      rofs_in  = rofs_ff;
      rover_in = rover_ff;
      pos_in   = pos_ff;
      if (cmd.commit) begin
         value_in = is_read_ff ? (aligned & keep) : '0;
         rofs_in  = ofs_ff;
         rover_in = over_ff;
         pos_in   = tgt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff <= is_read_in;
      n_ff       <= n_in;
      cut_ff     <= cut_in;
      over_ff    <= over_in;
      ofs_ff     <= ofs_in;
      tgt_ff     <= tgt_in;
      hi_ff      <= hi_in;
      win_ff     <= win_in;
      value_ff   <= value_in;
      rofs_ff    <= rofs_in;
      rover_ff   <= rover_in;
   end

   assign rsp_value       = value_ff;
   assign rsp_byte_offset = rofs_ff;
   assign rsp_past_end    = rover_ff;
endmodule
`default_nettype wire

>>> sv/msb_first_bit_reader.sv
// Top level of the MSB-first bit reader: controller, datapath and channel hookup.
`default_nettype none
// MSB-first bitstream reader. Bytes are loaded into an internal buffer by address;
// a bit position starting at zero walks the buffer. Each request beat gives exactly
// one response beat. A read returns the next 0 to 64 bits, first bit most
// significant, right-aligned; skip and take advance the position by bits or bytes,
// take reporting the byte offset it started from; restart zeroes the position.
// Bits past the buffer end read as zero, the position stops at the end and
// past_end is raised, as it is for a read count above MAX_READ_BITS. Reads from
// buffer bytes never loaded return undefined data. Load, skip, take and restart
// go from the request beat straight to the response state; a read first makes
// the two word fetches from the eight byte-wide RAM banks (one read port) that an
// unaligned 64-bit field spanning nine bytes needs, plus one alignment stage.
// One request is in flight at a time; a finished response waits in an output
// register while the next request is taken. No clearing pass follows reset.
module msb_first_bit_reader #(
   parameter int BUFFER_BYTES  = 4096,
   parameter int MAX_READ_BITS = 64
) (
   input wire logic clock,
   input wire logic reset,
   mbr_req_if.sink  req,
   mbr_rsp_if.source rsp
);
   import mbr_pkg::*;

   mbr_cmd_type  cmd;
   mbr_stat_type stat;

   mbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mbr_dpath #(
      .BUFFER_BYTES  (BUFFER_BYTES),
      .MAX_READ_BITS (MAX_READ_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req.op),
      .req_load_address (req.load_address),
      .req_load_byte    (req.load_byte),
      .req_count        (req.count),
      .rsp_value        (rsp.value),
      .rsp_byte_offset  (rsp.byte_offset),
      .rsp_past_end     (rsp.past_end)
   );
endmodule
`default_nettype wire
